FILE: rtl/core/tilemap_collision_slide_top_defines.svh
// Assertion macros for the tile map collision block.
// Included by the top level; depends on nothing else.
`ifndef TILEMAP_COLLISION_SLIDE_TOP_DEFINES_SVH
`define TILEMAP_COLLISION_SLIDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcs assertion failed");
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcs assertion failed");
`else
`define TCS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/tcs_pkg.sv
// Shared types, codes and constants of the tile map collision block.
// Depends on nothing; used by tilemap_collision_slide_top.
package tcs_pkg;

   localparam int COORD_W     = 26;
   localparam int DIV_CNT_W   = 5;
   localparam int REQ_DATA_W  = 136;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic OP_WRITE    = 1'b0;
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   localparam logic [6:0]  RST_MAP_COLUMNS = 7'd64;
   localparam logic [6:0]  RST_MAP_ROWS    = 7'd64;
   localparam logic [7:0]  RST_TILE_WIDTH  = 8'd16;
   localparam logic [7:0]  RST_TILE_HEIGHT = 8'd16;

   typedef enum logic [2:0] {
      CSR_MAP_COLUMNS = 3'd0,
      CSR_MAP_ROWS    = 3'd1,
      CSR_TILE_WIDTH  = 3'd2,
      CSR_TILE_HEIGHT = 3'd3,
      CSR_ORIGIN_X    = 3'd4,
      CSR_ORIGIN_Y    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_DIV_LOAD, ST_DIV, ST_DIV_END, ST_RANGE,
      ST_MUL, ST_TILE_RD, ST_TILE_CHK, ST_CIRC, ST_PASS_END, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PASS_FULL = 2'd0,
      PASS_X    = 2'd1,
      PASS_Y    = 2'd2
   } pass_type;

   // Division by 16 that truncates toward zero, as pixel conversion needs.
   function automatic logic signed [COORD_W-1:0] trunc16(
      input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W-1:0] t;
      t = v[COORD_W-1] ? (v + $signed(COORD_W'(15))) : v;
      return t >>> 4;
   endfunction

endpackage

FILE: rtl/core/tilemap_collision_slide_top.sv
// Tile map collision with per-axis slide: a 1-bit tile store and a query sequencer.
// A query runs one to three passes, each a range set-up with four divisions and a scan
// of the tiles under the body, with a distance check per solid tile for circles.
// One item at a time: a new beat is taken only while idle, so the range divisions and
// the tile scan through the single store read port set the throughput.
// Reset: synchronous; afterwards a clearing pass writes every tile of the store empty.
// Depends on tcs_pkg and tilemap_collision_slide_top_defines.svh.
`include "tilemap_collision_slide_top_defines.svh"

module tilemap_collision_slide_top #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tile_index, tile_solid, body_x, body_y, body_width, body_height, radius,
   // move_x, move_y (from bit 0 up, zero padded to 136 bits)
   input  logic [tcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op, body_kind (from bit 0 up)
   input  logic [tcs_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // collided, allowed_x, allowed_y, hit_valid, hit_index (from bit 0 up, zero padded)
   output logic [tcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Store geometry. Every tile address fits below STORE_SIZE by construction.
   localparam int STORE_SIZE = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int CX_W       = $clog2(MAX_COLUMNS + 1);
   localparam int CY_W       = $clog2(MAX_ROWS + 1);
   localparam int CW         = tcs_pkg::COORD_W;

   // ---------------------------------------------------------------------------
   // Configuration registers, to be written only while the block is idle; not enforced here.
   // ---------------------------------------------------------------------------
   logic [6:0]         cfg_cols_ff, cfg_rows_ff;
   logic [7:0]         cfg_tw_ff, cfg_th_ff;
   logic signed [19:0] cfg_ox_ff, cfg_oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= tcs_pkg::RST_MAP_COLUMNS;
         cfg_rows_ff <= tcs_pkg::RST_MAP_ROWS;
         cfg_tw_ff   <= tcs_pkg::RST_TILE_WIDTH;
         cfg_th_ff   <= tcs_pkg::RST_TILE_HEIGHT;
         cfg_ox_ff   <= '0;
         cfg_oy_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tcs_pkg::CSR_MAP_COLUMNS: cfg_cols_ff <= csr_wdata[6:0];
            tcs_pkg::CSR_MAP_ROWS:    cfg_rows_ff <= csr_wdata[6:0];
            tcs_pkg::CSR_TILE_WIDTH:  cfg_tw_ff   <= csr_wdata[7:0];
            tcs_pkg::CSR_TILE_HEIGHT: cfg_th_ff   <= csr_wdata[7:0];
            tcs_pkg::CSR_ORIGIN_X:    cfg_ox_ff   <= csr_wdata;
            tcs_pkg::CSR_ORIGIN_Y:    cfg_oy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective map and tile sizes: zero reads as one, an oversize map size saturates.
   logic [CX_W-1:0] cols_eff;
   logic [CY_W-1:0] rows_eff;
   logic [7:0]      tw_eff, th_eff;

   always_comb begin
      if (cfg_cols_ff == 7'd0)
         cols_eff = CX_W'(1);
      else if (32'(cfg_cols_ff) > MAX_COLUMNS)
         cols_eff = CX_W'(MAX_COLUMNS);
      else
         cols_eff = CX_W'(cfg_cols_ff);
      if (cfg_rows_ff == 7'd0)
         rows_eff = CY_W'(1);
      else if (32'(cfg_rows_ff) > MAX_ROWS)
         rows_eff = CY_W'(MAX_ROWS);
      else
         rows_eff = CY_W'(cfg_rows_ff);
      tw_eff = (cfg_tw_ff == 8'd0) ? 8'd1 : cfg_tw_ff;
      th_eff = (cfg_th_ff == 8'd0) ? 8'd1 : cfg_th_ff;
   end

   // ---------------------------------------------------------------------------
   // Input beat fields.
   // ---------------------------------------------------------------------------
   logic               in_op, in_kind, in_solid;
   logic [11:0]        in_tile_index;
   logic signed [19:0] in_body_x, in_body_y;
   logic [15:0]        in_body_width, in_body_height, in_radius;
   logic signed [15:0] in_move_x, in_move_y;

   assign in_op          = req_tuser[0];
   assign in_kind        = req_tuser[1];
   assign in_tile_index  = req_tdata[11:0];
   assign in_solid       = req_tdata[12];
   assign in_body_x      = req_tdata[32:13];
   assign in_body_y      = req_tdata[52:33];
   assign in_body_width  = req_tdata[68:53];
   assign in_body_height = req_tdata[84:69];
   assign in_radius      = req_tdata[100:85];
   assign in_move_x      = req_tdata[116:101];
   assign in_move_y      = req_tdata[132:117];

   // ---------------------------------------------------------------------------
   // Sequencer state and datapath registers.
   // ---------------------------------------------------------------------------
   tcs_pkg::state_type state_ff, state_in;
   tcs_pkg::pass_type  pass_ff;

   logic [ADDR_W-1:0]  clr_addr_ff;

   logic               q_kind_ff;
   logic signed [19:0] q_bx_ff, q_by_ff;
   logic [15:0]        q_bw_ff, q_bh_ff, q_r_ff;
   logic signed [15:0] q_mx_ff, q_my_ff;

   logic signed [CW-1:0] rx_ff, ry_ff;
   logic signed [CW-1:0] c0_ff, c1_ff, r0_ff, r1_ff;
   logic [1:0]           div_sel_ff;
   logic [CW-1:0]        num_ff;
   logic [7:0]           rem_ff;
   logic                 neg_ff;
   logic [tcs_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   logic [1:0]           mul_sel_ff;
   logic [ADDR_W-1:0]    row_base_ff;
   logic [CX_W-1:0]      cx_ff;
   logic [CY_W-1:0]      cy_ff;
   logic signed [CW-1:0] bx_start_ff, bx_ff, by_ff;
   logic                 rd_data_ff;
   logic [15:0]          dx_mag_ff, dy_mag_ff;
   logic                 far_ff;
   logic [32:0]          acc_ff;

   logic                 pass_hit_ff;
   logic [ADDR_W-1:0]    tmp_idx_ff, rec_idx_ff;

   logic                 res_coll_ff, res_hv_ff;
   logic signed [15:0]   res_ax_ff, res_ay_ff;
   logic [11:0]          res_idx_ff;

   logic                           rsp_valid_ff;
   logic [tcs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic tile_mem [STORE_SIZE];

   // ---------------------------------------------------------------------------
   // Geometry of the current pass. The x-only pass keeps the old y, the
   // y-only pass keeps the old x.
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0] cur_x, cur_y, r_c, pw_c, ph_c, rx_raw, ry_raw;
   logic signed [CW-1:0] tw16, th16, cols_s, rows_s;

   always_comb begin
      cur_x = CW'(q_bx_ff);
      cur_y = CW'(q_by_ff);
      if (pass_ff != tcs_pkg::PASS_Y)
         cur_x = CW'(q_bx_ff) + CW'(q_mx_ff);
      if (pass_ff != tcs_pkg::PASS_X)
         cur_y = CW'(q_by_ff) + CW'(q_my_ff);
      r_c  = signed'(CW'(q_r_ff));
      // A circle's box starts at centre minus radius and spans twice the radius.
      if (q_kind_ff == tcs_pkg::KIND_CIRCLE) begin
         rx_raw = cur_x - r_c - CW'(cfg_ox_ff);
         ry_raw = cur_y - r_c - CW'(cfg_oy_ff);
         pw_c   = signed'(CW'(q_r_ff >> 3));
         ph_c   = pw_c;
      end else begin
         rx_raw = cur_x - CW'(cfg_ox_ff);
         ry_raw = cur_y - CW'(cfg_oy_ff);
         pw_c   = signed'(CW'(q_bw_ff >> 4));
         ph_c   = signed'(CW'(q_bh_ff >> 4));
      end
      tw16   = signed'(CW'({tw_eff, 4'b0000}));
      th16   = signed'(CW'({th_eff, 4'b0000}));
      cols_s = signed'(CW'(cols_eff));
      rows_s = signed'(CW'(rows_eff));
   end

   // ---------------------------------------------------------------------------
   // Shared restoring divider: one quotient bit per cycle on the magnitude,
   // sign put back at the end, which truncates toward zero.
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0] dvd_base, dvd_ext, dvd;
   logic [CW-1:0]        dvd_mag;
   logic [7:0]           dvs;
   logic [8:0]           trial;
   logic                 div_ge;
   logic [7:0]           rem_in;
   logic signed [CW-1:0] quo;

   always_comb begin
      dvd_base = div_sel_ff[1] ? ry_ff : rx_ff;
      dvd_ext  = div_sel_ff[1] ? ph_c : pw_c;
      dvd      = div_sel_ff[0] ? (dvd_base + dvd_ext) : dvd_base;
      dvd_mag  = dvd[CW-1] ? CW'(-dvd) : CW'(dvd);
      dvs      = div_sel_ff[1] ? th_eff : tw_eff;
      trial    = {rem_ff, num_ff[CW-1]};
      div_ge   = (trial >= {1'b0, dvs});
      rem_in   = div_ge ? 8'(trial - {1'b0, dvs}) : trial[7:0];
      quo      = neg_ff ? -signed'(num_ff) : signed'(num_ff);
   end

   // ---------------------------------------------------------------------------
   // Shared 16 x 16 multiplier: range set-up products and circle distances.
   // ---------------------------------------------------------------------------
   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == tcs_pkg::ST_MUL) begin
         unique case (mul_sel_ff)
            2'd0: begin
               mul_a = 16'(r0_ff);
               mul_b = 16'(cols_eff);
            end
            2'd1: begin
               mul_a = 16'(c0_ff);
               mul_b = 16'(tw_eff);
            end
            default: begin
               mul_a = 16'(r0_ff);
               mul_b = 16'(th_eff);
            end
         endcase
      end else if (state_ff == tcs_pkg::ST_CIRC) begin
         unique case (mul_sel_ff)
            2'd0: begin
               mul_a = dx_mag_ff;
               mul_b = dx_mag_ff;
            end
            2'd1: begin
               mul_a = dy_mag_ff;
               mul_b = dy_mag_ff;
            end
            default: begin
               mul_a = q_r_ff;
               mul_b = q_r_ff;
            end
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   // ---------------------------------------------------------------------------
   // Tile scan: address, closest-point distance and the step to the next tile.
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0]    scan_addr;
   logic signed [CW-1:0] bx1, by1, dxv, dyv;
   logic                 far_x, far_y, row_last, all_last, circ_hit;
   logic                 adv_en, hit_en;

   always_comb begin
      scan_addr = row_base_ff + ADDR_W'(cx_ff);
      bx1 = bx_ff + tw16;
      by1 = by_ff + th16;
      if (cur_x < bx_ff)
         dxv = bx_ff - cur_x;
      else if (cur_x > bx1)
         dxv = cur_x - bx1;
      else
         dxv = '0;
      if (cur_y < by_ff)
         dyv = by_ff - cur_y;
      else if (cur_y > by1)
         dyv = cur_y - by1;
      else
         dyv = '0;
      // An offset of 2^16 or more squares past any radius squared.
      far_x    = |dxv[CW-1:16];
      far_y    = |dyv[CW-1:16];
      row_last = (cx_ff == CX_W'(c1_ff));
      all_last = row_last && (cy_ff == CY_W'(r1_ff));
      circ_hit = !far_ff && (acc_ff < 33'(mul_p));
      adv_en   = ((state_ff == tcs_pkg::ST_TILE_CHK) && !rd_data_ff) ||
                 ((state_ff == tcs_pkg::ST_CIRC) && (mul_sel_ff == 2'd2) && !circ_hit);
      hit_en   = ((state_ff == tcs_pkg::ST_TILE_CHK) && rd_data_ff &&
                  (q_kind_ff == tcs_pkg::KIND_RECT)) ||
                 ((state_ff == tcs_pkg::ST_CIRC) && (mul_sel_ff == 2'd2) && circ_hit);
   end

   // ---------------------------------------------------------------------------
   // Handshake and store write port.
   // ---------------------------------------------------------------------------
   logic              req_accept, out_free, wr_in_range;
   logic              mem_we, mem_wdata;
   logic [ADDR_W-1:0] mem_waddr;

   always_comb begin
      req_tready  = (state_ff == tcs_pkg::ST_IDLE);
      req_accept  = req_tvalid && req_tready;
      out_free    = !rsp_valid_ff || rsp_tready;
      wr_in_range = (32'(in_tile_index) < STORE_SIZE);
      mem_we      = 1'b0;
      mem_waddr   = clr_addr_ff;
      mem_wdata   = 1'b0;
      if (state_ff == tcs_pkg::ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (req_accept && (in_op == tcs_pkg::OP_WRITE) && wr_in_range) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(in_tile_index);
         mem_wdata = in_solid;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         tile_mem[mem_waddr] <= mem_wdata;
      if (state_ff == tcs_pkg::ST_TILE_RD)
         rd_data_ff <= tile_mem[scan_addr];
   end

   // ---------------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcs_pkg::ST_CLEAR:
            if (clr_addr_ff == ADDR_W'(STORE_SIZE - 1))
               state_in = tcs_pkg::ST_IDLE;
         tcs_pkg::ST_IDLE:
            if (req_accept)
               state_in = (in_op == tcs_pkg::OP_WRITE) ? tcs_pkg::ST_DONE : tcs_pkg::ST_SETUP;
         tcs_pkg::ST_SETUP:    state_in = tcs_pkg::ST_DIV_LOAD;
         tcs_pkg::ST_DIV_LOAD: state_in = tcs_pkg::ST_DIV;
         tcs_pkg::ST_DIV:
            if (div_cnt_ff == tcs_pkg::DIV_CNT_W'(CW - 1))
               state_in = tcs_pkg::ST_DIV_END;
         tcs_pkg::ST_DIV_END:
            state_in = (div_sel_ff == 2'd3) ? tcs_pkg::ST_RANGE : tcs_pkg::ST_DIV_LOAD;
         tcs_pkg::ST_RANGE:
            if ((c0_ff > c1_ff) || (r0_ff > r1_ff))
               state_in = tcs_pkg::ST_PASS_END;
            else
               state_in = tcs_pkg::ST_MUL;
         tcs_pkg::ST_MUL:
            if (mul_sel_ff == 2'd2)
               state_in = tcs_pkg::ST_TILE_RD;
         tcs_pkg::ST_TILE_RD:  state_in = tcs_pkg::ST_TILE_CHK;
         tcs_pkg::ST_TILE_CHK: begin
            if (hit_en || (adv_en && all_last))
               state_in = tcs_pkg::ST_PASS_END;
            else if (adv_en)
               state_in = tcs_pkg::ST_TILE_RD;
            else
               state_in = tcs_pkg::ST_CIRC;
         end
         tcs_pkg::ST_CIRC: begin
            if (hit_en || (adv_en && all_last))
               state_in = tcs_pkg::ST_PASS_END;
            else if (adv_en)
               state_in = tcs_pkg::ST_TILE_RD;
         end
         tcs_pkg::ST_PASS_END: begin
            if (pass_ff == tcs_pkg::PASS_Y)
               state_in = tcs_pkg::ST_DONE;
            else if (pass_hit_ff)
               state_in = tcs_pkg::ST_SETUP;
            else
               state_in = tcs_pkg::ST_DONE;
         end
         tcs_pkg::ST_DONE:
            if (out_free)
               state_in = tcs_pkg::ST_IDLE;
         default: state_in = tcs_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcs_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tcs_pkg::ST_CLEAR)
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if ((state_ff == tcs_pkg::ST_DONE) && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tcs_pkg::ST_IDLE: begin
            if (req_accept) begin
               q_kind_ff <= in_kind;
               q_bx_ff   <= in_body_x;
               q_by_ff   <= in_body_y;
               q_bw_ff   <= in_body_width;
               q_bh_ff   <= in_body_height;
               q_r_ff    <= in_radius;
               q_mx_ff   <= in_move_x;
               q_my_ff   <= in_move_y;
               pass_ff   <= tcs_pkg::PASS_FULL;
               // A tile write answers with all fields zero.
               res_coll_ff <= 1'b0;
               res_hv_ff   <= 1'b0;
               res_ax_ff   <= '0;
               res_ay_ff   <= '0;
               res_idx_ff  <= '0;
            end
         end
         tcs_pkg::ST_SETUP: begin
            rx_ff      <= tcs_pkg::trunc16(rx_raw);
            ry_ff      <= tcs_pkg::trunc16(ry_raw);
            div_sel_ff <= 2'd0;
         end
         tcs_pkg::ST_DIV_LOAD: begin
            num_ff     <= dvd_mag;
            neg_ff     <= dvd[CW-1];
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         tcs_pkg::ST_DIV: begin
            rem_ff     <= rem_in;
            num_ff     <= {num_ff[CW-2:0], div_ge};
            div_cnt_ff <= div_cnt_ff + tcs_pkg::DIV_CNT_W'(1);
         end
         tcs_pkg::ST_DIV_END: begin
            // First index raised to zero, last lowered to the map size less one.
            unique case (div_sel_ff)
               2'd0: c0_ff <= quo[CW-1] ? '0 : quo;
               2'd1: c1_ff <= (quo >= cols_s) ? (cols_s - CW'(1)) : quo;
               2'd2: r0_ff <= quo[CW-1] ? '0 : quo;
               default: r1_ff <= (quo >= rows_s) ? (rows_s - CW'(1)) : quo;
            endcase
            div_sel_ff <= div_sel_ff + 2'd1;
            mul_sel_ff <= 2'd0;
         end
         tcs_pkg::ST_RANGE: begin
            pass_hit_ff <= 1'b0;
         end
         tcs_pkg::ST_MUL: begin
            unique case (mul_sel_ff)
               2'd0: begin
                  row_base_ff <= ADDR_W'(mul_p);
                  cx_ff       <= CX_W'(c0_ff);
                  cy_ff       <= CY_W'(r0_ff);
               end
               2'd1: begin
                  bx_start_ff <= signed'(CW'({mul_p, 4'b0000})) + CW'(cfg_ox_ff);
                  bx_ff       <= signed'(CW'({mul_p, 4'b0000})) + CW'(cfg_ox_ff);
               end
               default: by_ff <= signed'(CW'({mul_p, 4'b0000})) + CW'(cfg_oy_ff);
            endcase
            mul_sel_ff <= mul_sel_ff + 2'd1;
         end
         tcs_pkg::ST_TILE_RD: begin
            mul_sel_ff <= 2'd0;
         end
         tcs_pkg::ST_TILE_CHK: begin
            dx_mag_ff <= dxv[15:0];
            dy_mag_ff <= dyv[15:0];
            far_ff    <= far_x || far_y;
         end
         tcs_pkg::ST_CIRC: begin
            if (mul_sel_ff == 2'd0)
               acc_ff <= 33'(mul_p);
            else if (mul_sel_ff == 2'd1)
               acc_ff <= acc_ff + 33'(mul_p);
            mul_sel_ff <= mul_sel_ff + 2'd1;
         end
         tcs_pkg::ST_PASS_END: begin
            unique case (pass_ff)
               tcs_pkg::PASS_FULL: begin
                  res_coll_ff <= 1'b0;
                  res_hv_ff   <= 1'b0;
                  res_ax_ff   <= q_mx_ff;
                  res_ay_ff   <= q_my_ff;
                  res_idx_ff  <= '0;
                  if (pass_hit_ff)
                     pass_ff <= tcs_pkg::PASS_X;
               end
               tcs_pkg::PASS_X: begin
                  res_coll_ff <= 1'b1;
                  res_hv_ff   <= 1'b0;
                  res_ax_ff   <= q_mx_ff;
                  res_ay_ff   <= '0;
                  res_idx_ff  <= '0;
                  rec_idx_ff  <= tmp_idx_ff;
                  if (pass_hit_ff)
                     pass_ff <= tcs_pkg::PASS_Y;
               end
               default: begin
                  // A clear y-only move keeps y and the tile from the x-only pass.
                  res_coll_ff <= 1'b1;
                  res_hv_ff   <= 1'b1;
                  res_ax_ff   <= '0;
                  res_ay_ff   <= pass_hit_ff ? 16'sd0 : q_my_ff;
                  res_idx_ff  <= 12'(pass_hit_ff ? tmp_idx_ff : rec_idx_ff);
               end
            endcase
         end
         tcs_pkg::ST_DONE: begin
            if (out_free)
               rsp_data_ff <= {2'b00, res_idx_ff, res_hv_ff, res_ay_ff, res_ax_ff,
                               res_coll_ff};
         end
         default: ;
      endcase

      // Scan outcome, shared by the rectangle and circle paths.
      if (hit_en) begin
         pass_hit_ff <= 1'b1;
         tmp_idx_ff  <= scan_addr;
      end else if (adv_en) begin
         if (all_last) begin
            pass_hit_ff <= 1'b0;
         end else if (row_last) begin
            cx_ff       <= CX_W'(c0_ff);
            cy_ff       <= cy_ff + CY_W'(1);
            row_base_ff <= row_base_ff + ADDR_W'(cols_eff);
            bx_ff       <= bx_start_ff;
            by_ff       <= by_ff + th16;
         end else begin
            cx_ff <= cx_ff + CX_W'(1);
            bx_ff <= bx_ff + tw16;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   `TCS_ASSERT_IMP(a_clear_blocks_input, clock, reset, state_ff == tcs_pkg::ST_CLEAR, !req_tready)
   `TCS_ASSERT_IMP(a_hit_needs_collision, clock, reset, rsp_tvalid && !rsp_tdata[0], !rsp_tdata[33])
   `TCS_ASSERT_IMP(a_scan_in_store, clock, reset, state_ff == tcs_pkg::ST_TILE_RD, 32'(scan_addr) < STORE_SIZE)
   `TCS_ASSERT_NEXT(a_done_to_idle, clock, reset, (state_ff == tcs_pkg::ST_DONE) && out_free, (state_ff == tcs_pkg::ST_IDLE) && rsp_tvalid)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for tilemap_collision_slide_top: tile writes and move queries
// are driven as stream beats and every response beat is checked against a local model or a table row.
// Depends on tcs_pkg and the RTL of tilemap_collision_slide_top.
`timescale 1ns / 100ps

module tb;

   localparam int          STORE_DEPTH = 64 * 64;
   localparam int unsigned CYCLE_LIMIT = 5_000_000;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 175;
   localparam logic        OP_QUERY    = ~tcs_pkg::OP_WRITE;

   typedef struct {
      logic        collided;
      logic [15:0] allowed_x;
      logic [15:0] allowed_y;
      logic        hit_valid;
      logic [11:0] hit_index;
   } move_result_type;

   typedef struct {
      logic        op;
      logic [11:0] tile_index;
      logic        tile_solid;
      logic        body_kind;
      logic [19:0] body_x;
      logic [19:0] body_y;
      logic [15:0] body_width;
      logic [15:0] body_height;
      logic [15:0] radius;
      logic [15:0] move_x;
      logic [15:0] move_y;
   } tile_item_type;

   typedef struct {
      tile_item_type   item;
      bit              typed;   // expected result written into the row
      move_result_type result;
   } directed_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [tcs_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic [tcs_pkg::REQ_USER_W-1:0]     req_tuser = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b1;
   logic [tcs_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                               csr_we = 1'b0;
   logic [tcs_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [tcs_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   // Local copy of the block's state and registers.
   bit           solid_tiles[STORE_DEPTH];
   logic [6:0]   columns_reg;
   logic [6:0]   rows_reg;
   logic [7:0]   tile_w_reg;
   logic [7:0]   tile_h_reg;
   logic [19:0]  origin_x_reg;
   logic [19:0]  origin_y_reg;

   move_result_type pending_moves[$];
   int           error_count = 0;
   int           beats_checked = 0;
   int unsigned  cycle_count = 0;
   bit           calm = 1'b0;       // no idling on either side
   bit           squeeze_done = 1'b0;

   tilemap_collision_slide_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Registers as the block uses them: zero sizes count as one, map sizes saturate at 64.
   function automatic longint used_size(longint v, longint hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Scans the tiles under one body position; returns 1 on the first solid tile touched.
   function automatic bit body_hits_tile(bit kind, longint x, longint y, longint w, longint h,
                                         longint r, output longint hit);
      longint cols, rows, tw, th, ox, oy, rx, ry, pw, ph, c0, c1, r0, r1, idx;
      longint bx0, by0, bx1, by1, px, py, dx, dy;
      cols = used_size(longint'(columns_reg), 64);
      rows = used_size(longint'(rows_reg), 64);
      tw   = used_size(longint'(tile_w_reg), 255);
      th   = used_size(longint'(tile_h_reg), 255);
      ox   = longint'($signed(origin_x_reg));
      oy   = longint'($signed(origin_y_reg));
      hit  = 0;
      if (kind == tcs_pkg::KIND_CIRCLE) begin
         rx = x - r - ox;
         ry = y - r - oy;
         pw = (2 * r) / 16;
         ph = pw;
      end else begin
         rx = x - ox;
         ry = y - oy;
         pw = w / 16;
         ph = h / 16;
      end
      rx = rx / 16;
      ry = ry / 16;
      c0 = rx / tw;
      c1 = (rx + pw) / tw;
      r0 = ry / th;
      r1 = (ry + ph) / th;
      if (c0 < 0) c0 = 0;
      if (c1 >= cols) c1 = cols - 1;
      if (r0 < 0) r0 = 0;
      if (r1 >= rows) r1 = rows - 1;
      for (longint cy = r0; cy <= r1; cy++) begin
         for (longint cx = c0; cx <= c1; cx++) begin
            idx = cy * cols + cx;
            if (idx < 0 || idx >= STORE_DEPTH || !solid_tiles[idx]) continue;
            if (kind == tcs_pkg::KIND_CIRCLE) begin
               bx0 = cx * tw * 16 + ox;
               by0 = cy * th * 16 + oy;
               bx1 = bx0 + tw * 16;
               by1 = by0 + th * 16;
               px = (x < bx0) ? bx0 : ((x > bx1) ? bx1 : x);
               py = (y < by0) ? by0 : ((y > by1) ? by1 : y);
               dx = x - px;
               dy = y - py;
               if (!(dx * dx + dy * dy < r * r)) continue;
            end
            hit = idx;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Applies one accepted beat to the local state and returns the response it should cause.
   function automatic move_result_type slide_move(tile_item_type it);
      move_result_type res;
      longint bx, by, mx, my, w, h, r, hit, unused;
      res = '{1'b0, 16'd0, 16'd0, 1'b0, 12'd0};
      if (it.op == tcs_pkg::OP_WRITE) begin
         solid_tiles[it.tile_index] = it.tile_solid;
         return res;
      end
      bx = longint'($signed(it.body_x));
      by = longint'($signed(it.body_y));
      mx = longint'($signed(it.move_x));
      my = longint'($signed(it.move_y));
      w  = longint'(it.body_width);
      h  = longint'(it.body_height);
      r  = longint'(it.radius);
      res.allowed_x = it.move_x;
      res.allowed_y = it.move_y;
      if (!body_hits_tile(it.body_kind, bx + mx, by + my, w, h, r, unused)) return res;
      res.collided = 1'b1;
      if (!body_hits_tile(it.body_kind, bx + mx, by, w, h, r, hit)) begin
         res.allowed_y = '0;
      end else begin
         res.hit_valid = 1'b1;
         res.hit_index = hit[11:0];
         res.allowed_x = '0;
         if (body_hits_tile(it.body_kind, bx, by + my, w, h, r, hit)) begin
            res.allowed_y = '0;
            res.hit_index = hit[11:0];
         end
      end
      return res;
   endfunction

   function automatic tile_item_type tile_write(int index, bit solid);
      tile_item_type it;
      it = '{default: '0};
      it.op = tcs_pkg::OP_WRITE;
      it.tile_index = index[11:0];
      it.tile_solid = solid;
      return it;
   endfunction

   function automatic tile_item_type move_query(bit kind, int x, int y, int w, int h, int r,
                                                int mx, int my);
      tile_item_type it;
      it = '{default: '0};
      it.op = OP_QUERY;
      it.body_kind = kind;
      it.body_x = x[19:0];
      it.body_y = y[19:0];
      it.body_width = w[15:0];
      it.body_height = h[15:0];
      it.radius = r[15:0];
      it.move_x = mx[15:0];
      it.move_y = my[15:0];
      return it;
   endfunction

   // Offers one beat, with an occasional gap before it, and waits for the handshake.
   task automatic send_item(tile_item_type it);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {it.body_kind, it.op};
      req_tdata  <= {3'b0, it.move_y, it.move_x, it.radius, it.body_height, it.body_width,
                     it.body_y, it.body_x, it.tile_solid, it.tile_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller drops it after the last register.
   task automatic write_register(tcs_pkg::csr_index_type index,
                                 logic [tcs_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      unique case (index)
         tcs_pkg::CSR_MAP_COLUMNS: columns_reg  = value[6:0];
         tcs_pkg::CSR_MAP_ROWS:    rows_reg     = value[6:0];
         tcs_pkg::CSR_TILE_WIDTH:  tile_w_reg   = value[7:0];
         tcs_pkg::CSR_TILE_HEIGHT: tile_h_reg   = value[7:0];
         tcs_pkg::CSR_ORIGIN_X:    origin_x_reg = value;
         tcs_pkg::CSR_ORIGIN_Y:    origin_y_reg = value;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Random beat shaped by the current map: mostly writes inside the map and small bodies
   // near it, with some full-range noise.
   function automatic tile_item_type random_item();
      int cols, rows, tw, th, span_x, span_y, ox, oy, pick;
      cols = int'(used_size(longint'(columns_reg), 64));
      rows = int'(used_size(longint'(rows_reg), 64));
      tw   = int'(used_size(longint'(tile_w_reg), 255)) * 16;
      th   = int'(used_size(longint'(tile_h_reg), 255)) * 16;
      span_x = cols * tw;
      span_y = rows * th;
      ox = int'($signed(origin_x_reg));
      oy = int'($signed(origin_y_reg));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         if ($urandom_range(0, 5) == 0) return tile_write($urandom_range(0, 4095),
                                                          $urandom_range(0, 1));
         return tile_write($urandom_range(0, cols * rows - 1), $urandom_range(0, 9) < 4);
      end
      if (pick < 91)
         return move_query($urandom_range(0, 1),
                           ox + $urandom_range(0, span_x + 2 * tw) - tw,
                           oy + $urandom_range(0, span_y + 2 * th) - th,
                           $urandom_range(0, 2 * tw), $urandom_range(0, 2 * th),
                           $urandom_range(0, tw + th),
                           $urandom_range(0, 2 * tw) - tw, $urandom_range(0, 2 * th) - th);
      // Noise: any position and move; full-range sizes only now and then, as they are slow.
      return move_query($urandom_range(0, 1), $urandom, $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 255),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 255),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 255),
                        $urandom, $urandom);
   endfunction

   // Register settings per phase: columns, rows, tile width, tile height, origin x, origin y.
   // The extremes are here: zero sizes taken as one, oversized maps saturated, both origin ends.
   int phase_setting[PHASES][6] = '{
      '{64,  64,  16,  16,  0,       0},
      '{1,   1,   255, 255, -524288, 524287},
      '{0,   127, 0,   1,   -1000,   2000},
      '{64,  1,   1,   255, 524287,  -524288},
      '{13,  37,  7,   9,   -3000,   -50},
      '{64,  64,  255, 255, 1234,    -777}
   };

   directed_row_type directed[$];

   // Stimulus: directed table, then random phases, each under a new register setting.
   initial begin
      move_result_type predicted;
      columns_reg  = tcs_pkg::RST_MAP_COLUMNS;
      rows_reg     = tcs_pkg::RST_MAP_ROWS;
      tile_w_reg   = tcs_pkg::RST_TILE_WIDTH;
      tile_h_reg   = tcs_pkg::RST_TILE_HEIGHT;
      origin_x_reg = '0;
      origin_y_reg = '0;

      // After reset the map is empty, so a query passes unchanged.
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 0, 0, 256, 256, 0, 100, -100), 1'b1,
                           '{1'b0, 16'd100, -16'sd100, 1'b0, 12'd0}});
      // Extreme centre, radius and moves; the box lies wholly outside the map.
      directed.push_back('{move_query(tcs_pkg::KIND_CIRCLE, -524288, 524287, 0, 0, 65535,
                                      -32768, 32767), 1'b1,
                           '{1'b0, 16'h8000, 16'h7fff, 1'b0, 12'd0}});
      directed.push_back('{tile_write(0, 1), 1'b1, '{default: '0}});
      directed.push_back('{tile_write(4095, 1), 1'b1, '{default: '0}});
      directed.push_back('{tile_write(65, 1), 1'b1, '{default: '0}});
      // Body sitting on tile 0 without moving: every pass hits, both components blocked.
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 0, 0, 256, 256, 0, 0, 0), 1'b1,
                           '{1'b1, 16'd0, 16'd0, 1'b1, 12'd0}});
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 640, 320, 128, 128, 0, 320, 0),
                           1'b0, '{default: '0}});
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 320, 640, 128, 128, 0, 0, 320),
                           1'b0, '{default: '0}});
      directed.push_back('{move_query(tcs_pkg::KIND_CIRCLE, 384, 384, 0, 0, 128, 16, 16),
                           1'b0, '{default: '0}});
      directed.push_back('{move_query(tcs_pkg::KIND_CIRCLE, 512, 300, 0, 0, 100, -200, 300),
                           1'b0, '{default: '0}});
      // Largest rectangle: every tile of the map is under it.
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 0, 0, 65535, 65535, 0,
                                      -32768, -32768), 1'b0, '{default: '0}});
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 16256, 16256, 0, 0, 0, 0, 0), 1'b0,
                           '{default: '0}});
      // A zero radius never touches anything.
      directed.push_back('{move_query(tcs_pkg::KIND_CIRCLE, 260, 260, 0, 0, 0, 5, -7), 1'b1,
                           '{1'b0, 16'd5, -16'sd7, 1'b0, 12'd0}});
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, -64000, -64000, 4000, 4000, 0,
                                      32767, 32767), 1'b0, '{default: '0}});
      directed.push_back('{tile_write(0, 0), 1'b1, '{default: '0}});
      directed.push_back('{tile_write(4095, 0), 1'b1, '{default: '0}});
      // Tile 65 is still solid and lies under the body in every pass.
      directed.push_back('{move_query(tcs_pkg::KIND_RECT, 0, 0, 256, 256, 0, 8, 8), 1'b1,
                           '{1'b1, 16'd0, 16'd0, 1'b1, 12'd65}});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_item(directed[i].item);
         predicted = slide_move(directed[i].item);
         pending_moves.push_back(directed[i].typed ? directed[i].result : predicted);
      end

      for (int p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         drain();
         calm = (p == PHASES - 1);
         write_register(tcs_pkg::CSR_MAP_COLUMNS,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][0]));
         write_register(tcs_pkg::CSR_MAP_ROWS,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][1]));
         write_register(tcs_pkg::CSR_TILE_WIDTH,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][2]));
         write_register(tcs_pkg::CSR_TILE_HEIGHT,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][3]));
         write_register(tcs_pkg::CSR_ORIGIN_X,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][4]));
         write_register(tcs_pkg::CSR_ORIGIN_Y,
                        tcs_pkg::CSR_DATA_W'(phase_setting[p][5]));
         csr_we <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            tile_item_type it;
            it = random_item();
            send_item(it);
            pending_moves.push_back(slide_move(it));
         end
      end
      req_tvalid <= 1'b0;

      while (pending_moves.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Response side: random stalls, and once a long hold-off so that the block backs up.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && !squeeze_done && beats_checked >= 300) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            squeeze_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checks each response beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_moves.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            move_result_type exp_move;
            exp_move = pending_moves.pop_front();
            if (rsp_tdata[0] !== exp_move.collided) begin
               $error("collided: expected %0d, got %0d", exp_move.collided, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[16:1] !== exp_move.allowed_x) begin
               $error("allowed_x: expected %0d, got %0d", $signed(exp_move.allowed_x),
                      $signed(rsp_tdata[16:1]));
               error_count++;
            end
            if (rsp_tdata[32:17] !== exp_move.allowed_y) begin
               $error("allowed_y: expected %0d, got %0d", $signed(exp_move.allowed_y),
                      $signed(rsp_tdata[32:17]));
               error_count++;
            end
            if (rsp_tdata[33] !== exp_move.hit_valid) begin
               $error("hit_valid: expected %0d, got %0d", exp_move.hit_valid, rsp_tdata[33]);
               error_count++;
            end
            if (rsp_tdata[45:34] !== exp_move.hit_index) begin
               $error("hit_index: expected %0d, got %0d", exp_move.hit_index,
                      rsp_tdata[45:34]);
               error_count++;
            end
         end
         beats_checked++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
